/* rtl/ubhf_pkg.sv */
// shared types, codes and helpers for the bulk-out header framer
// no dependencies; imported by every module of the block
package ubhf_pkg;

    // default receive buffer size in bytes
    localparam int BUFFER_BYTES_DEF = 64;

    // bulk header length and message ids
    localparam int unsigned HDR_LEN = 12;
    localparam logic [7:0] MSG_DEV_DEP_OUT    = 8'd1;
    localparam logic [7:0] MSG_REQ_DEV_DEP_IN = 8'd2;

    // header byte positions
    localparam int unsigned POS_MSG_ID   = 0;
    localparam int unsigned POS_TAG      = 1;
    localparam int unsigned POS_TAG_INV  = 2;
    localparam int unsigned POS_SIZE0    = 4;
    localparam int unsigned POS_SIZE1    = 5;
    localparam int unsigned POS_SIZE2    = 6;
    localparam int unsigned POS_SIZE3    = 7;
    localparam int unsigned POS_ATTR     = 8;

    // attribute values
    localparam logic [7:0] ATTR_EOM  = 8'd1;
    localparam logic [7:0] ATTR_NONE = 8'd0;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_OUT   = 2'd0,
        VERDICT_IN    = 2'd1,
        VERDICT_STALL = 2'd2
    } verdict_t;

    // one queue entry: the work caused by one accepted input byte
    typedef struct packed {
        logic       pay_vld;
        logic [7:0] pay_byte;
        logic       vrd_vld;
        verdict_t   verdict;
        logic [5:0] plen;
        logic [6:0] tlen;
        logic       hdr_vld;
        logic [7:0] tag;
        logic [6:0] rlen;
    } entry_t;

    // response header byte at position idx
    function automatic logic [7:0] resp_hdr_byte(input logic [3:0] idx,
                                                 input logic [7:0] tag,
                                                 input logic [6:0] rlen);
        logic [7:0] res;
        unique case (idx)
            4'd0:    res = MSG_REQ_DEV_DEP_IN;
            4'd1:    res = tag;
            4'd2:    res = ~tag;
            4'd4:    res = {1'b0, rlen};
            4'd8:    res = ATTR_EOM;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

/* rtl/ubhf_front.sv */
// front part: header capture, payload pass decision and packet verdict
// depends on ubhf_pkg; feeds ubhf_queue
module ubhf_front
    import ubhf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       end_of_packet,
    input  logic       reply_available,
    input  logic [6:0] reply_length,
    output logic       push,
    output entry_t     entry
);

    localparam int PW = $clog2(BUFFER_BYTES + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    tag_reg, tag_next;
    logic [7:0]    tinv_reg, tinv_next;
    logic [31:0]   size_reg, size_next;
    logic [7:0]    attr_reg, attr_next;
    logic          ovf_reg, ovf_next;

    logic            accept;
    logic            store;
    logic            pay;
    logic            tag_ok;
    logic            len_ok;
    logic            size_ok;
    logic            rlen_ok;
    logic [PW:0]     size_rnd;
    logic [PW+1:0]   pad_len;
    logic [7:0]      rlen_rnd;
    logic [7:0]      tlen_full;
    verdict_t        verdict;

    assign accept = in_valid & in_ready;

    // header capture for this byte
    always_comb
    begin
        ovf_next  = ovf_reg | (pos_reg == PW'(BUFFER_BYTES));
        store     = ~ovf_next;
        id_next   = id_reg;
        tag_next  = tag_reg;
        tinv_next = tinv_reg;
        size_next = size_reg;
        attr_next = attr_reg;
        if (store)
        begin
            if (pos_reg == PW'(POS_MSG_ID))  id_next = rx_byte;
            if (pos_reg == PW'(POS_TAG))     tag_next = rx_byte;
            if (pos_reg == PW'(POS_TAG_INV)) tinv_next = rx_byte;
            if (pos_reg == PW'(POS_SIZE0))   size_next[7:0] = rx_byte;
            if (pos_reg == PW'(POS_SIZE1))   size_next[15:8] = rx_byte;
            if (pos_reg == PW'(POS_SIZE2))   size_next[23:16] = rx_byte;
            if (pos_reg == PW'(POS_SIZE3))   size_next[31:24] = rx_byte;
            if (pos_reg == PW'(POS_ATTR))    attr_next = rx_byte;
        end
        pos_next = store ? pos_reg + PW'(1) : pos_reg;
    end

    // payload bytes inside the announced transfer size
    assign pay = store && (id_reg == MSG_DEV_DEP_OUT) && (pos_reg >= PW'(HDR_LEN))
                 && ((32'(pos_reg) - 32'(HDR_LEN)) < size_reg);

    // verdict checks on the updated header
    assign tag_ok   = (tag_next == ~tinv_next);
    assign len_ok   = ~ovf_next && (pos_next >= PW'(HDR_LEN)) && tag_ok;
    assign size_ok  = (size_next <= 32'(BUFFER_BYTES - 13));
    assign size_rnd = ({1'b0, size_next[PW-1:0]} + (PW+1)'(3)) & ~(PW+1)'(3);
    assign pad_len  = {1'b0, size_rnd} + (PW+2)'(HDR_LEN);
    assign rlen_ok  = ({25'd0, reply_length} <= 32'(BUFFER_BYTES - 12));
    assign rlen_rnd = ({1'b0, reply_length} + 8'd3) & ~8'd3;
    assign tlen_full = rlen_rnd + 8'(HDR_LEN);

    logic out_ok;
    logic in_ok;

    assign out_ok = len_ok && (id_next == MSG_DEV_DEP_OUT) && size_ok
                    && (attr_next == ATTR_EOM) && ({2'b00, pos_next} == pad_len);
    assign in_ok  = len_ok && (id_next == MSG_REQ_DEV_DEP_IN)
                    && (pos_next == PW'(HDR_LEN)) && (attr_next == ATTR_NONE)
                    && reply_available && rlen_ok;

    always_comb
    begin
        priority if (out_ok)
            verdict = VERDICT_OUT;
        else if (in_ok)
            verdict = VERDICT_IN;
        else
            verdict = VERDICT_STALL;
    end

    // queue entry for this transaction
    always_comb
    begin
        entry.pay_vld  = pay;
        entry.pay_byte = rx_byte;
        entry.vrd_vld  = end_of_packet;
        entry.verdict  = verdict;
        entry.plen     = out_ok ? size_next[5:0] : 6'd0;
        entry.tlen     = in_ok ? tlen_full[6:0] : 7'd0;
        entry.hdr_vld  = in_ok;
        entry.tag      = tag_next;
        entry.rlen     = reply_length;
    end

    assign push = accept & (pay | end_of_packet);

    // header state, cleared after every packet end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            id_reg   <= '0;
            tag_reg  <= '0;
            tinv_reg <= '0;
            size_reg <= '0;
            attr_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_packet)
            begin
                pos_reg  <= '0;
                id_reg   <= '0;
                tag_reg  <= '0;
                tinv_reg <= '0;
                size_reg <= '0;
                attr_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                pos_reg  <= pos_next;
                id_reg   <= id_next;
                tag_reg  <= tag_next;
                tinv_reg <= tinv_next;
                size_reg <= size_next;
                attr_reg <= attr_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

endmodule

/* rtl/ubhf_queue.sv */
// short fifo of work entries between the front and back parts
// depends on ubhf_pkg for the entry type
module ubhf_queue
    import ubhf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wr_entry,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    entry_t          mem [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // fill count update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (AW+1)'(1);
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/ubhf_back.sv */
// back part: expands queue entries into result transactions
// depends on ubhf_pkg; drains ubhf_queue into the output register
module ubhf_back
    import ubhf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output kind_t       item_kind,
    output logic [7:0]  data_byte,
    output verdict_t    verdict,
    output logic [5:0]  payload_length,
    output logic [6:0]  transmit_length,
    output logic        last_of_run
);

    logic [3:0]  step_reg;
    logic [3:0]  hidx;
    logic        is_pay;
    logic        is_hdr;
    logic        is_last;
    logic        load;

    logic        valid_reg;
    kind_t       kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    verdict_t    vrd_reg, vrd_next;
    logic [5:0]  plen_reg, plen_next;
    logic [6:0]  tlen_reg, tlen_next;
    logic        last_reg;

    // which result of the head entry is due
    assign is_pay  = head.pay_vld && (step_reg == 4'd0);
    assign hidx    = step_reg - {3'd0, head.pay_vld};
    assign is_hdr  = !is_pay && head.hdr_vld && (hidx < 4'(HDR_LEN));
    assign is_last = is_pay ? !head.vrd_vld : !is_hdr;
    assign load    = !empty && (!valid_reg || out_ready);
    assign pop     = load && is_last;

    always_comb
    begin
        kind_next = KIND_VERDICT;
        data_next = 8'h00;
        vrd_next  = VERDICT_OUT;
        plen_next = 6'd0;
        tlen_next = 7'd0;
        if (is_pay)
        begin
            kind_next = KIND_PAYLOAD;
            data_next = head.pay_byte;
        end
        else if (is_hdr)
        begin
            kind_next = KIND_HEADER;
            data_next = resp_hdr_byte(hidx, head.tag, head.rlen);
        end
        else
        begin
            vrd_next  = head.verdict;
            plen_next = head.plen;
            tlen_next = head.tlen;
        end
    end

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                step_reg <= is_last ? 4'd0 : step_reg + 4'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            vrd_reg  <= vrd_next;
            plen_reg <= plen_next;
            tlen_reg <= tlen_next;
            last_reg <= is_last;
        end
    end

    assign out_valid       = valid_reg;
    assign item_kind       = kind_reg;
    assign data_byte       = data_reg;
    assign verdict         = vrd_reg;
    assign payload_length  = plen_reg;
    assign transmit_length = tlen_reg;
    assign last_of_run     = last_reg;

endmodule

/* rtl/usbtmc_bulk_header_framer_unit.sv */
// Bulk-out message header framer: checks the 12-byte bulk header of each
// received packet, passes data-out payload and answers data-in requests.
// Input channel (s_*): one packet byte per transaction, tlast on the final
//   byte; reply_available and reply_length are sampled with that byte.
// Output channel (m_*): results; tuser gives the kind (payload byte,
//   response header byte, verdict), tlast marks the final result caused by
//   one input byte.
// Path: an accepted byte is written into the queue, and its first result
//   is then loaded from the queue head into the output register (later if
//   earlier results wait).
// Throughput: one input byte per cycle while the queue is not full; each
//   byte yields at most two results, except an accepted data-in request
//   whose 12 response header bytes and verdict make 13 results. A 4-entry
//   queue between the header decoder and the result sequencer absorbs the difference.
// A stalled receiver holds the output register; input keeps flowing until
//   the queue fills, then s_tready drops.
// Reset clears the header state, the queue and the output valid; the block
//   takes bytes right after reset.
module usbtmc_bulk_header_framer_unit
    import ubhf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], reply_available[8], reply_length[15:9]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte[7:0], verdict[9:8], payload_length[15:10],
                                   // transmit_length[22:16], zero[23]
    output logic [1:0]  m_tuser,   // item_kind[1:0]
    output logic        m_tlast
);

    logic       q_push;
    entry_t     q_in;
    logic       q_pop;
    entry_t     q_head;
    logic       q_full;
    logic       q_empty;
    kind_t      item_kind;
    logic [7:0] data_byte;
    verdict_t   verdict;
    logic [5:0] payload_length;
    logic [6:0] transmit_length;

    assign s_tready = ~q_full;

    // header decode and classification
    ubhf_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .rx_byte         (s_tdata[7:0]),
        .end_of_packet   (s_tlast),
        .reply_available (s_tdata[8]),
        .reply_length    (s_tdata[15:9]),
        .push            (q_push),
        .entry           (q_in)
    );

    // work queue
    ubhf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // result sequencer
    ubhf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .empty           (q_empty),
        .pop             (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .item_kind       (item_kind),
        .data_byte       (data_byte),
        .verdict         (verdict),
        .payload_length  (payload_length),
        .transmit_length (transmit_length),
        .last_of_run     (m_tlast)
    );

    assign m_tdata = {1'b0, transmit_length, payload_length, verdict, data_byte};
    assign m_tuser = item_kind;

endmodule

/* tb/ubhf_framer_checker.sv */
// result checker for the bulk-out header framer: decodes each input transaction
// in its own header model and compares every output transaction in order
// depends on ubhf_pkg for the kind and verdict codes and the header constants
module ubhf_framer_checker
    import ubhf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // rx_byte[7:0], reply_available[8], reply_length[15:9]
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // data_byte[7:0], verdict[9:8], payload_length[15:10],
                                    // transmit_length[22:16], zero[23]
    input  logic [1:0]  m_tuser,    // item_kind[1:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          outstanding
);

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        verdict_t   verdict;
        logic [5:0] plen;
        logic [6:0] tlen;
        logic       last;
    } framer_item_t;

    // results predicted but not yet seen on the output
    framer_item_t predicted_items[$];

    // header capture state of the model
    logic [6:0]  hdr_pos;
    logic [7:0]  hdr_id;
    logic [7:0]  hdr_tag;
    logic [7:0]  hdr_tag_inv;
    logic [31:0] hdr_size;
    logic [7:0]  hdr_attr;
    logic        hdr_overflow;

    int fails = 0;
    int pending_n = 0;

    assign fail_count  = fails;
    assign outstanding = pending_n;

    task automatic clear_header();
        hdr_pos      = '0;
        hdr_id       = '0;
        hdr_tag      = '0;
        hdr_tag_inv  = '0;
        hdr_size     = '0;
        hdr_attr     = '0;
        hdr_overflow = 1'b0;
    endtask

    task automatic push_item(input kind_t kind, input logic [7:0] data,
                             input verdict_t vrd, input logic [5:0] plen,
                             input logic [6:0] tlen);
        framer_item_t item;
        item.kind    = kind;
        item.data    = data;
        item.verdict = vrd;
        item.plen    = plen;
        item.tlen    = tlen;
        item.last    = 1'b0;
        predicted_items.push_back(item);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        framer_item_t want;
        int           first_new;
        logic [7:0]   rx_b;
        logic         rx_eop;
        logic         rx_avail;
        logic [6:0]   rx_rlen;
        logic [31:0]  padded;
        logic [7:0]   resp [12];
        verdict_t     vrd;
        logic [5:0]   plen;
        logic [6:0]   tlen;

        if (!rst_n)
        begin
            predicted_items.delete();
            clear_header();
        end
        else
        begin
            // compare an output transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (predicted_items.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d data %0d",
                             $time, m_tuser, m_tdata);
                    fails++;
                end
                else
                begin
                    want = predicted_items.pop_front();
                    check_field("item_kind", want.kind, m_tuser);
                    check_field("data_byte", want.data, m_tdata[7:0]);
                    check_field("verdict", want.verdict, m_tdata[9:8]);
                    check_field("payload_length", want.plen, m_tdata[15:10]);
                    check_field("transmit_length", want.tlen, m_tdata[22:16]);
                    check_field("pad bit", 0, m_tdata[23]);
                    check_field("last_of_run", want.last, m_tlast);
                end
            end

            // predict the results of an input transaction
            if (s_tvalid && s_tready)
            begin
                rx_b      = s_tdata[7:0];
                rx_avail  = s_tdata[8];
                rx_rlen   = s_tdata[15:9];
                rx_eop    = s_tlast;
                first_new = predicted_items.size();

                // capture header fields, pass payload of a data-out message
                if (hdr_overflow || hdr_pos >= BUFFER_BYTES)
                    hdr_overflow = 1'b1;
                else
                begin
                    case (hdr_pos)
                        POS_MSG_ID:  hdr_id = rx_b;
                        POS_TAG:     hdr_tag = rx_b;
                        POS_TAG_INV: hdr_tag_inv = rx_b;
                        POS_SIZE0:   hdr_size[7:0] = rx_b;
                        POS_SIZE1:   hdr_size[15:8] = rx_b;
                        POS_SIZE2:   hdr_size[23:16] = rx_b;
                        POS_SIZE3:   hdr_size[31:24] = rx_b;
                        POS_ATTR:    hdr_attr = rx_b;
                        default:     ;
                    endcase
                    if (hdr_id == MSG_DEV_DEP_OUT && hdr_pos >= HDR_LEN &&
                        (32'(hdr_pos) - HDR_LEN) < hdr_size)
                        push_item(KIND_PAYLOAD, rx_b, VERDICT_OUT, '0, '0);
                    hdr_pos = hdr_pos + 7'd1;
                end

                // verdict at packet end
                if (rx_eop)
                begin
                    vrd  = VERDICT_STALL;
                    plen = '0;
                    tlen = '0;
                    if (!hdr_overflow && hdr_pos >= HDR_LEN && hdr_tag == ~hdr_tag_inv)
                    begin
                        if (hdr_id == MSG_DEV_DEP_OUT)
                        begin
                            padded = ((hdr_size + 32'd3) / 32'd4) * 32'd4 + HDR_LEN;
                            if (hdr_size <= BUFFER_BYTES - 13 && hdr_attr == ATTR_EOM &&
                                32'(hdr_pos) == padded)
                            begin
                                vrd  = VERDICT_OUT;
                                plen = hdr_size[5:0];
                            end
                        end
                        else if (hdr_id == MSG_REQ_DEV_DEP_IN)
                        begin
                            if (hdr_pos == HDR_LEN && hdr_attr == ATTR_NONE && rx_avail &&
                                rx_rlen <= BUFFER_BYTES - 12)
                            begin
                                resp = '{MSG_REQ_DEV_DEP_IN, hdr_tag, ~hdr_tag, 8'h00,
                                         {1'b0, rx_rlen}, 8'h00, 8'h00, 8'h00,
                                         ATTR_EOM, 8'h00, 8'h00, 8'h00};
                                foreach (resp[i])
                                    push_item(KIND_HEADER, resp[i], VERDICT_OUT, '0, '0);
                                vrd    = VERDICT_IN;
                                padded = ((32'(rx_rlen) + 32'd3) / 32'd4) * 32'd4 + HDR_LEN;
                                tlen   = padded[6:0];
                            end
                        end
                    end
                    push_item(KIND_VERDICT, 8'h00, vrd, plen, tlen);
                    clear_header();
                end

                // mark the final result of this byte
                if (predicted_items.size() > first_new)
                    predicted_items[predicted_items.size() - 1].last = 1'b1;
            end
        end
        pending_n = predicted_items.size();
    end

endmodule

/* tb/tb_usbtmc_bulk_header_framer_unit.sv */
// testbench top for the bulk-out header framer: builds directed and random
// packets, idles both channels and reports the verdict of ubhf_framer_checker
// depends on ubhf_pkg, usbtmc_bulk_header_framer_unit and ubhf_framer_checker
module tb_usbtmc_bulk_header_framer_unit;
    import ubhf_pkg::*;

    localparam int RUN_BYTES   = 450;
    localparam int QUIET_BYTES = 380;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          outstanding;

    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          stall_left = 0;
    int          calm_left = 0;

    // bytes of the packet being assembled
    logic [7:0]  pkt_bytes[$];

    usbtmc_bulk_header_framer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ubhf_framer_checker #(
        .BUFFER_BYTES (BUFFER_BYTES_DEF)
    ) framer_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls in bursts, with calm stretches in between
    always @(negedge clk)
    begin
        if (bytes_sent >= QUIET_BYTES)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (calm_left > 0)
        begin
            m_tready <= 1'b1;
            calm_left--;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    m_tready   <= 1'b0;
                    stall_left = $urandom_range(0, 17);
                end
                2:
                begin
                    m_tready  <= 1'b1;
                    calm_left = $urandom_range(20, 60);
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // one input transaction, with an optional idle burst before it
    task automatic send_byte(input logic [7:0] b, input logic eop,
                             input logic avail, input logic [6:0] rlen);
        @(negedge clk);
        if (bytes_sent < QUIET_BYTES && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rlen, avail, b};
        s_tlast  <= eop;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // send the assembled packet; reply fields only matter on the last byte
    task automatic send_packet(input logic avail, input logic [6:0] rlen);
        foreach (pkt_bytes[i])
        begin
            if (i == pkt_bytes.size() - 1)
                send_byte(pkt_bytes[i], 1'b1, avail, rlen);
            else
                send_byte(pkt_bytes[i], 1'b0, 1'($urandom_range(0, 1)),
                          7'($urandom_range(0, 127)));
        end
        pkt_bytes.delete();
    endtask

    // hold off the sender until every predicted result has come out
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic put_random(input int n);
        repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // 12-byte bulk header, reserved bytes random
    task automatic put_header(input logic [7:0] id, input logic [7:0] tag,
                              input logic [7:0] tag_inv, input logic [31:0] size,
                              input logic [7:0] attr);
        pkt_bytes.push_back(id);
        pkt_bytes.push_back(tag);
        pkt_bytes.push_back(tag_inv);
        put_random(1);
        pkt_bytes.push_back(size[7:0]);
        pkt_bytes.push_back(size[15:8]);
        pkt_bytes.push_back(size[23:16]);
        pkt_bytes.push_back(size[31:24]);
        pkt_bytes.push_back(attr);
        put_random(3);
    endtask

    // well-formed data-out message with padded payload
    task automatic put_data_out(input int size);
        logic [7:0] tag;
        tag = 8'($urandom_range(0, 255));
        put_header(MSG_DEV_DEP_OUT, tag, ~tag, size, ATTR_EOM);
        put_random(((size + 3) / 4) * 4);
    endtask

    // well-formed data-in request, requested size random
    task automatic put_data_in();
        logic [7:0] tag;
        tag = 8'($urandom_range(0, 255));
        put_header(MSG_REQ_DEV_DEP_IN, tag, ~tag, $urandom, ATTR_NONE);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: short packet of one byte
        pkt_bytes.push_back(MSG_DEV_DEP_OUT);
        send_packet(1'b1, 7'd0);
        // data-out with empty payload, tag extremes
        put_header(MSG_DEV_DEP_OUT, 8'h00, 8'hFF, 32'd0, ATTR_EOM);
        send_packet(1'b0, 7'd127);
        // data-out of five bytes with padding
        put_header(MSG_DEV_DEP_OUT, 8'hFF, 8'h00, 32'd5, ATTR_EOM);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        put_random(6);
        send_packet(1'b0, 7'd0);
        // data-in with empty reply and the largest reply
        put_header(MSG_REQ_DEV_DEP_IN, 8'h5A, 8'hA5, 32'hFFFF_FFFF, ATTR_NONE);
        send_packet(1'b1, 7'd0);
        put_data_in();
        send_packet(1'b1, 7'(BUFFER_BYTES_DEF - 12));
        // data-in with reply too long, no reply waiting, packet too long
        put_data_in();
        send_packet(1'b1, 7'd127);
        put_data_in();
        send_packet(1'b0, 7'd4);
        put_data_in();
        put_random(1);
        send_packet(1'b1, 7'd4);
        // unknown message id and failed tag check
        put_header(8'hFF, 8'h00, 8'hFF, 32'd0, ATTR_EOM);
        send_packet(1'b1, 7'd4);
        put_header(MSG_DEV_DEP_OUT, 8'h12, 8'h12, 32'd0, ATTR_EOM);
        send_packet(1'b1, 7'd4);
        // largest data-out that fits, then an overlong packet
        put_data_out(BUFFER_BYTES_DEF - 13);
        send_packet(1'b1, 7'd4);
        put_data_out(BUFFER_BYTES_DEF - 13);
        put_random(2);
        send_packet(1'b1, 7'd4);
        drain();

        // random packets, mostly well formed
        while (bytes_sent < RUN_BYTES)
        begin : random_packet
            int         pick;
            int         size;
            int         n;
            logic [7:0] tag;
            logic [7:0] id;
            logic [7:0] flip;
            logic [7:0] attr;
            logic       avail;
            logic [6:0] rlen;

            tag   = 8'($urandom_range(0, 255));
            flip  = 8'h01 << $urandom_range(0, 7);
            id    = $urandom_range(0, 1) ? MSG_DEV_DEP_OUT : MSG_REQ_DEV_DEP_IN;
            avail = 1'b1;
            rlen  = 7'($urandom_range(0, BUFFER_BYTES_DEF - 12));
            size  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BUFFER_BYTES_DEF - 13)
                                                : $urandom_range(0, 12);
            pick  = $urandom_range(0, 99);
            if (pick < 35)
                put_data_out(size);
            else if (pick < 65)
            begin
                put_data_in();
                if ($urandom_range(0, 9) == 0)
                    avail = 1'b0;
                if ($urandom_range(0, 7) == 0)
                    rlen = 7'($urandom_range(BUFFER_BYTES_DEF - 11, 127));
            end
            else if (pick < 70)
            begin
                // tag check fails
                put_header(id, tag, ~tag ^ flip, size,
                           (id == MSG_DEV_DEP_OUT) ? ATTR_EOM : ATTR_NONE);
                if (id == MSG_DEV_DEP_OUT)
                    put_random(((size + 3) / 4) * 4);
            end
            else if (pick < 75)
            begin
                // wrong attribute byte
                attr = ((id == MSG_DEV_DEP_OUT) ? ATTR_EOM : ATTR_NONE) ^ flip;
                put_header(id, tag, ~tag, size, attr);
                if (id == MSG_DEV_DEP_OUT)
                    put_random(((size + 3) / 4) * 4);
            end
            else if (pick < 81)
            begin
                // length off by a few bytes
                if (id == MSG_DEV_DEP_OUT)
                    put_data_out(size);
                else
                    put_data_in();
                n = $urandom_range(1, 4);
                if ($urandom_range(0, 1))
                    put_random(n);
                else
                    repeat (n) void'(pkt_bytes.pop_back());
            end
            else if (pick < 85)
            begin
                // transfer size too large for the buffer
                put_header(MSG_DEV_DEP_OUT, tag, ~tag,
                           $urandom_range(0, 1) ? $urandom_range(BUFFER_BYTES_DEF - 12, 255)
                                                : $urandom,
                           ATTR_EOM);
                put_random($urandom_range(0, 20));
            end
            else if (pick < 89)
            begin
                // unknown message id
                put_header($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(3, 255)),
                           tag, ~tag, size, ATTR_EOM);
                put_random($urandom_range(0, 8));
            end
            else if (pick < 94)
            begin
                // short packet
                put_random($urandom_range(1, 11));
                if ($urandom_range(0, 1))
                    pkt_bytes[0] = id;
            end
            else if (pick < 97)
            begin
                // overlong packet
                put_data_out(BUFFER_BYTES_DEF - 13);
                put_random($urandom_range(1, 6));
            end
            else
                put_random($urandom_range(1, 30));
            send_packet(avail, rlen);
            if ($urandom_range(0, 39) == 0)
                drain();
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
